// ===== design/forest_leaf_peel_layering_macros.svh =====
// Assertion macros for the leaf peeling block and its checker.
`ifndef FOREST_LEAF_PEEL_LAYERING_MACROS_SVH
`define FOREST_LEAF_PEEL_LAYERING_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, idle during reset.
`define FLP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("flp assertion failed");

// Next-cycle implication.
`define FLP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("flp assertion failed");

`endif

// ===== design/flp_pkg.sv =====
// Shared types, codes and default sizes of the leaf peeling block.
package flp_pkg;

   localparam int MAX_NODE_DEF   = 1024;
   localparam int MAX_DEGREE_DEF = 32;
   localparam int MAX_EDGE_DEF   = 1024;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_RUN   = 2'd2;
   localparam logic [1:0] MODE_READ  = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_DEGREE = 2'd1;
   localparam logic [1:0] STATUS_CYCLE  = 2'd2;
   localparam logic [1:0] STATUS_RANGE  = 2'd3;

   localparam logic REG_NODE_COUNT = 1'b0;

   typedef struct packed {
      logic [1:0]  mode;
      logic [9:0]  node_a;
      logic [9:0]  node_b;
      logic [63:0] edge_weight;
      logic [9:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] layer_total;
      logic [10:0] entry_total;
      logic [9:0]  entry_node;
      logic [9:0]  entry_parent;
      logic        has_parent;
      logic [9:0]  entry_layer;
      logic [63:0] parent_weight;
   } rsp_type;

endpackage

// ===== design/flp_ram.sv =====
// Single-port synchronous RAM with registered read data.
module flp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/flp_seq.sv =====
// Sequencer and node, edge, adjacency and order memories of the peeling block.
module flp_seq #(
   parameter int MAX_NODE   = flp_pkg::MAX_NODE_DEF,
   parameter int MAX_DEGREE = flp_pkg::MAX_DEGREE_DEF,
   parameter int MAX_EDGE   = flp_pkg::MAX_EDGE_DEF,
   localparam int NCW = $clog2(MAX_NODE + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [NCW-1:0]    node_limit,
   input  logic              req_valid,
   output logic              req_ready,
   input  flp_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output flp_pkg::rsp_type  rsp_data
);

   localparam int NW   = $clog2(MAX_NODE);
   localparam int SW   = $clog2(MAX_DEGREE);
   localparam int DW   = SW;
   localparam int EIW  = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
   localparam int ECW  = $clog2(MAX_EDGE + 1);
   localparam int LW   = $clog2(MAX_EDGE + 2);
   localparam int XW   = (NCW > 10) ? NCW : 10;
   localparam int AAW  = NW + SW;
   localparam int EDW  = 2 * NW + 64;
   localparam int IFW  = 1 + NW + LW + 64;
   localparam int TW   = 1 + LW;

   localparam logic [4:0] ST_CLR     = 5'd0;
   localparam logic [4:0] ST_IDLE    = 5'd1;
   localparam logic [4:0] ST_ADD_A   = 5'd2;
   localparam logic [4:0] ST_ADD_B   = 5'd3;
   localparam logic [4:0] ST_ADD_CHK = 5'd4;
   localparam logic [4:0] ST_ADD_WB  = 5'd5;
   localparam logic [4:0] ST_LK_RD   = 5'd6;
   localparam logic [4:0] ST_LK_A    = 5'd7;
   localparam logic [4:0] ST_LK_AW   = 5'd8;
   localparam logic [4:0] ST_LK_B    = 5'd9;
   localparam logic [4:0] ST_LK_BW   = 5'd10;
   localparam logic [4:0] ST_PL_RD   = 5'd11;
   localparam logic [4:0] ST_PL_CK   = 5'd12;
   localparam logic [4:0] ST_PL_EDGE = 5'd13;
   localparam logic [4:0] ST_PL_PAR  = 5'd14;
   localparam logic [4:0] ST_PL_DP   = 5'd15;
   localparam logic [4:0] ST_PL_SRD  = 5'd16;
   localparam logic [4:0] ST_PL_SCK  = 5'd17;
   localparam logic [4:0] ST_PL_W0   = 5'd18;
   localparam logic [4:0] ST_PL_W1   = 5'd19;
   localparam logic [4:0] ST_PL_END  = 5'd20;
   localparam logic [4:0] ST_RT_RD   = 5'd21;
   localparam logic [4:0] ST_RT_CK   = 5'd22;
   localparam logic [4:0] ST_RD_IDX  = 5'd23;
   localparam logic [4:0] ST_RD_ORD  = 5'd24;
   localparam logic [4:0] ST_RD_INF  = 5'd25;
   localparam logic [4:0] ST_RESP    = 5'd26;

   localparam logic [1:0] PH_CLEAR     = 2'd0;
   localparam logic [1:0] PH_RUN_START = 2'd1;
   localparam logic [1:0] PH_RUN_END   = 2'd2;

   // control state
   logic [4:0]     state_ff, state_in;
   logic [1:0]     phase_ff, phase_in;
   logic [NCW-1:0] i_ff, i_in;
   logic [ECW-1:0] e_ff, e_in;
   logic [ECW-1:0] ecnt_ff, ecnt_in;
   logic [ECW-1:0] live_ff, live_in;
   logic [LW-1:0]  layer_ff, layer_in;
   logic [NCW-1:0] cnt_ff, cnt_in;
   logic [LW-1:0]  lcnt_ff, lcnt_in;
   logic [NCW-1:0] entry_ff, entry_in;
   logic [1:0]     err_ff, err_in;
   logic           cyc_ff, cyc_in;
   logic           removed_ff, removed_in;
   logic           lim_all_ff, lim_all_in;
   logic           found_ff, found_in;
   logic [DW-1:0]  k_ff, k_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // payload
   flp_pkg::req_type req_ff, req_in;
   flp_pkg::rsp_type res_ff, res_in;
   flp_pkg::rsp_type rsp_ff, rsp_in;
   logic [DW-1:0]    da_ff, da_in;
   logic [DW-1:0]    db_ff, db_in;
   logic [DW-1:0]    dp_ff, dp_in;
   logic [NW-1:0]    la_ff, la_in;
   logic [NW-1:0]    lb_ff, lb_in;
   logic [NW-1:0]    p_ff, p_in;
   logic [EIW-1:0]   eidx_ff, eidx_in;
   logic [63:0]      pw_ff, pw_in;

   // memory ports
   logic            deg_we, touch_we, info_we, order_we, edge_we, adj_we;
   logic [NW-1:0]   deg_addr, touch_addr, info_addr, order_addr;
   logic [EIW-1:0]  edge_addr;
   logic [AAW-1:0]  adj_addr;
   logic [DW-1:0]   deg_wd, deg_rd;
   logic [TW-1:0]   touch_wd, touch_rd;
   logic [IFW-1:0]  info_wd, info_rd;
   logic [NW-1:0]   order_wd, order_rd;
   logic [EDW-1:0]  edge_wd, edge_rd;
   logic [EIW-1:0]  adj_wd, adj_rd;

   flp_ram #(.WIDTH(DW), .DEPTH(MAX_NODE)) u_deg (
      .clock(clock), .we(deg_we), .addr(deg_addr), .wdata(deg_wd), .rdata(deg_rd));
   flp_ram #(.WIDTH(TW), .DEPTH(MAX_NODE)) u_touch (
      .clock(clock), .we(touch_we), .addr(touch_addr), .wdata(touch_wd), .rdata(touch_rd));
   flp_ram #(.WIDTH(IFW), .DEPTH(MAX_NODE)) u_info (
      .clock(clock), .we(info_we), .addr(info_addr), .wdata(info_wd), .rdata(info_rd));
   flp_ram #(.WIDTH(NW), .DEPTH(MAX_NODE)) u_order (
      .clock(clock), .we(order_we), .addr(order_addr), .wdata(order_wd), .rdata(order_rd));
   flp_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGE)) u_edge (
      .clock(clock), .we(edge_we), .addr(edge_addr), .wdata(edge_wd), .rdata(edge_rd));
   flp_ram #(.WIDTH(EIW), .DEPTH(MAX_NODE * (2 ** SW))) u_adj (
      .clock(clock), .we(adj_we), .addr(adj_addr), .wdata(adj_wd), .rdata(adj_rd));

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic [NW-1:0]   node_i;
      logic [NW-1:0]   ra, rb;
      logic [NW-1:0]   ea, eb, pn;
      logic [DW+1:0]   need_sum;
      logic [DW+1:0]   b_sum;
      logic            bad_a, bad_b;
      node_i = i_ff[NW-1:0];
      ra     = NW'(req_ff.node_a);
      rb     = NW'(req_ff.node_b);
      ea     = edge_rd[EDW-1 -: NW];
      eb     = edge_rd[64 +: NW];
      pn     = (ea == node_i) ? eb : ea;
      need_sum = (DW+2)'(da_ff) + ((ra == rb) ? (DW+2)'(2) : (DW+2)'(1));
      b_sum    = (DW+2)'(deg_rd) + (DW+2)'(1);
      bad_a  = need_sum > (DW+2)'(MAX_DEGREE - 1);
      bad_b  = (ra != rb) && (b_sum > (DW+2)'(MAX_DEGREE - 1));

      state_in   = state_ff;
      phase_in   = phase_ff;
      i_in       = i_ff;
      e_in       = e_ff;
      ecnt_in    = ecnt_ff;
      live_in    = live_ff;
      layer_in   = layer_ff;
      cnt_in     = cnt_ff;
      lcnt_in    = lcnt_ff;
      entry_in   = entry_ff;
      err_in     = err_ff;
      cyc_in     = cyc_ff;
      removed_in = removed_ff;
      lim_all_in = lim_all_ff;
      found_in   = found_ff;
      k_in       = k_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_in  = req_ff;
      res_in  = res_ff;
      rsp_in  = rsp_ff;
      da_in   = da_ff;
      db_in   = db_ff;
      dp_in   = dp_ff;
      la_in   = la_ff;
      lb_in   = lb_ff;
      p_in    = p_ff;
      eidx_in = eidx_ff;
      pw_in   = pw_ff;

      deg_we = 1'b0;   deg_addr = node_i;   deg_wd = '0;
      touch_we = 1'b0; touch_addr = node_i; touch_wd = '0;
      info_we = 1'b0;  info_addr = node_i;  info_wd = '0;
      order_we = 1'b0; order_addr = cnt_ff[NW-1:0]; order_wd = node_i;
      edge_we = 1'b0;  edge_addr = e_ff[EIW-1:0];   edge_wd = '0;
      adj_we = 1'b0;   adj_addr = {la_ff, da_ff};   adj_wd = '0;

      unique case (state_ff)
         ST_CLR: begin
            if (i_ff == NCW'(MAX_NODE)) begin
               i_in = '0;
               e_in = '0;
               unique case (phase_ff)
                  PH_CLEAR: state_in = ST_IDLE;
                  PH_RUN_START: begin
                     lim_all_in = 1'b0;
                     live_in    = '0;
                     state_in   = ST_LK_RD;
                  end
                  default: begin
                     lim_all_in = 1'b1;
                     state_in   = ST_LK_RD;
                  end
               endcase
            end else begin
               deg_we = 1'b1;
               // final rebuild keeps the results of the run
               touch_we = (phase_ff != PH_RUN_END);
               info_we  = (phase_ff != PH_RUN_END);
               i_in = i_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               unique case (req_data.mode)
                  flp_pkg::MODE_CLEAR: begin
                     err_in   = flp_pkg::STATUS_OK;
                     ecnt_in  = '0;
                     lcnt_in  = '0;
                     entry_in = '0;
                     i_in     = '0;
                     phase_in = PH_CLEAR;
                     state_in = ST_CLR;
                  end
                  flp_pkg::MODE_ADD: state_in = ST_ADD_A;
                  flp_pkg::MODE_RUN: begin
                     i_in     = '0;
                     phase_in = PH_RUN_START;
                     state_in = ST_CLR;
                  end
                  default: state_in = ST_RD_IDX;
               endcase
            end
         end

         ST_ADD_A: begin
            res_in = '0;
            res_in.layer_total = 11'(lcnt_ff);
            res_in.entry_total = 11'(entry_ff);
            if ((XW'(req_ff.node_a) >= XW'(node_limit)) ||
                (XW'(req_ff.node_b) >= XW'(node_limit)) ||
                (ecnt_ff >= ECW'(MAX_EDGE))) begin
               res_in.status = flp_pkg::STATUS_RANGE;
               err_in   = flp_pkg::STATUS_RANGE;
               state_in = ST_RESP;
            end else begin
               deg_addr = ra;
               state_in = ST_ADD_B;
            end
         end

         ST_ADD_B: begin
            da_in    = deg_rd;
            deg_addr = rb;
            state_in = ST_ADD_CHK;
         end

         ST_ADD_CHK: begin
            if (bad_a || bad_b) begin
               res_in.status = flp_pkg::STATUS_DEGREE;
               err_in   = flp_pkg::STATUS_DEGREE;
               state_in = ST_RESP;
            end else begin
               db_in     = deg_rd;
               edge_we   = 1'b1;
               edge_addr = ecnt_ff[EIW-1:0];
               edge_wd   = {ra, rb, req_ff.edge_weight};
               deg_we    = 1'b1;
               deg_addr  = ra;
               deg_wd    = DW'(need_sum);
               adj_we    = 1'b1;
               adj_addr  = {ra, da_ff};
               adj_wd    = ecnt_ff[EIW-1:0];
               state_in  = ST_ADD_WB;
            end
         end

         ST_ADD_WB: begin
            // a self-loop takes the next slot of the same node
            deg_we   = (ra != rb);
            deg_addr = rb;
            deg_wd   = db_ff + 1'b1;
            adj_we   = 1'b1;
            adj_addr = (ra == rb) ? {ra, SW'(da_ff + 1'b1)} : {rb, db_ff};
            adj_wd   = ecnt_ff[EIW-1:0];
            ecnt_in  = ecnt_ff + 1'b1;
            res_in.status = flp_pkg::STATUS_OK;
            state_in = ST_RESP;
         end

         ST_LK_RD: begin
            if (e_ff == ecnt_ff) begin
               if (phase_ff == PH_RUN_START) begin
                  layer_in   = '0;
                  cnt_in     = '0;
                  i_in       = '0;
                  removed_in = 1'b0;
                  cyc_in     = 1'b0;
                  state_in   = (live_ff == '0) ? ST_RT_RD : ST_PL_RD;
               end else begin
                  res_in = '0;
                  res_in.status      = err_ff;
                  res_in.layer_total = 11'(lcnt_ff);
                  res_in.entry_total = 11'(entry_ff);
                  state_in = ST_RESP;
               end
            end else begin
               edge_addr = e_ff[EIW-1:0];
               state_in  = ST_LK_A;
            end
         end

         ST_LK_A: begin
            la_in = ea;
            lb_in = eb;
            if (!lim_all_ff && ((NCW'(ea) >= node_limit) || (NCW'(eb) >= node_limit))) begin
               e_in     = e_ff + 1'b1;
               state_in = ST_LK_RD;
            end else begin
               deg_addr = ea;
               state_in = ST_LK_AW;
            end
         end

         ST_LK_AW: begin
            deg_we   = 1'b1;
            deg_addr = la_ff;
            deg_wd   = deg_rd + 1'b1;
            adj_we   = 1'b1;
            adj_addr = {la_ff, deg_rd};
            adj_wd   = e_ff[EIW-1:0];
            state_in = ST_LK_B;
         end

         ST_LK_B: begin
            deg_addr = lb_ff;
            state_in = ST_LK_BW;
         end

         ST_LK_BW: begin
            deg_we   = 1'b1;
            deg_addr = lb_ff;
            deg_wd   = deg_rd + 1'b1;
            adj_we   = 1'b1;
            adj_addr = {lb_ff, deg_rd};
            adj_wd   = e_ff[EIW-1:0];
            e_in     = e_ff + 1'b1;
            if (!lim_all_ff) begin
               live_in = live_ff + 1'b1;
            end
            state_in = ST_LK_RD;
         end

         ST_PL_RD: begin
            if (i_ff == node_limit) begin
               state_in = ST_PL_END;
            end else begin
               state_in = ST_PL_CK;
            end
         end

         ST_PL_CK: begin
            if ((deg_rd != DW'(1)) || (touch_rd[LW] && (touch_rd[LW-1:0] == layer_ff))) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_PL_RD;
            end else begin
               adj_addr = {node_i, SW'(0)};
               state_in = ST_PL_EDGE;
            end
         end

         ST_PL_EDGE: begin
            eidx_in   = adj_rd;
            edge_addr = adj_rd;
            state_in  = ST_PL_PAR;
         end

         ST_PL_PAR: begin
            p_in  = pn;
            pw_in = edge_rd[63:0];
            if ((NCW'(pn) >= node_limit) || (pn == node_i)) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_PL_RD;
            end else begin
               deg_addr = pn;
               state_in = ST_PL_DP;
            end
         end

         ST_PL_DP: begin
            dp_in    = deg_rd;
            k_in     = '0;
            found_in = 1'b0;
            state_in = ST_PL_SRD;
         end

         ST_PL_SRD: begin
            if (k_ff == dp_ff) begin
               state_in = ST_PL_W0;
            end else begin
               adj_addr = {p_ff, k_ff};
               state_in = ST_PL_SCK;
            end
         end

         ST_PL_SCK: begin
            // entries after the removed edge move down one slot
            if (found_ff) begin
               adj_we   = 1'b1;
               adj_addr = {p_ff, SW'(k_ff - 1'b1)};
               adj_wd   = adj_rd;
            end else if (adj_rd == eidx_ff) begin
               found_in = 1'b1;
            end
            k_in     = k_ff + 1'b1;
            state_in = ST_PL_SRD;
         end

         ST_PL_W0: begin
            deg_we     = found_ff;
            deg_addr   = p_ff;
            deg_wd     = dp_ff - 1'b1;
            touch_we   = 1'b1;
            touch_addr = p_ff;
            touch_wd   = {1'b1, layer_ff};
            order_we   = 1'b1;
            info_we    = 1'b1;
            info_wd    = {1'b1, p_ff, layer_ff, pw_ff};
            state_in   = ST_PL_W1;
         end

         ST_PL_W1: begin
            deg_we     = 1'b1;
            deg_wd     = '0;
            touch_we   = 1'b1;
            touch_wd   = {1'b1, layer_ff};
            cnt_in     = cnt_ff + 1'b1;
            removed_in = 1'b1;
            live_in    = live_ff - 1'b1;
            i_in       = i_ff + 1'b1;
            state_in   = ST_PL_RD;
         end

         ST_PL_END: begin
            i_in       = '0;
            removed_in = 1'b0;
            if (!removed_ff) begin
               cyc_in   = 1'b1;
               state_in = ST_RT_RD;
            end else begin
               layer_in = layer_ff + 1'b1;
               state_in = (live_ff == '0) ? ST_RT_RD : ST_PL_RD;
            end
         end

         ST_RT_RD: begin
            if (i_ff == node_limit) begin
               lcnt_in  = layer_ff + 1'b1;
               entry_in = cnt_ff;
               if (cyc_ff) begin
                  err_in = flp_pkg::STATUS_CYCLE;
               end
               i_in     = '0;
               phase_in = PH_RUN_END;
               state_in = ST_CLR;
            end else begin
               state_in = ST_RT_CK;
            end
         end

         ST_RT_CK: begin
            if (!info_rd[IFW-1]) begin
               order_we = 1'b1;
               info_we  = 1'b1;
               info_wd  = {1'b0, NW'(0), layer_ff, 64'd0};
               cnt_in   = cnt_ff + 1'b1;
            end
            i_in     = i_ff + 1'b1;
            state_in = ST_RT_RD;
         end

         ST_RD_IDX: begin
            res_in = '0;
            res_in.layer_total = 11'(lcnt_ff);
            res_in.entry_total = 11'(entry_ff);
            if ((XW'(req_ff.read_index) >= XW'(entry_ff)) ||
                (XW'(req_ff.read_index) >= XW'(MAX_NODE))) begin
               res_in.status = flp_pkg::STATUS_RANGE;
               state_in = ST_RESP;
            end else begin
               order_addr = NW'(req_ff.read_index);
               state_in   = ST_RD_ORD;
            end
         end

         ST_RD_ORD: begin
            p_in      = order_rd;
            info_addr = order_rd;
            state_in  = ST_RD_INF;
         end

         ST_RD_INF: begin
            res_in.status      = err_ff;
            res_in.entry_node  = 10'(p_ff);
            res_in.has_parent  = info_rd[IFW-1];
            res_in.entry_layer = 10'(info_rd[64 +: LW]);
            if (info_rd[IFW-1]) begin
               res_in.entry_parent  = 10'(info_rd[LW+64 +: NW]);
               res_in.parent_weight = info_rd[63:0];
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         phase_ff     <= PH_CLEAR;
         i_ff         <= '0;
         e_ff         <= '0;
         ecnt_ff      <= '0;
         live_ff      <= '0;
         layer_ff     <= '0;
         cnt_ff       <= '0;
         lcnt_ff      <= '0;
         entry_ff     <= '0;
         err_ff       <= flp_pkg::STATUS_OK;
         cyc_ff       <= 1'b0;
         removed_ff   <= 1'b0;
         lim_all_ff   <= 1'b0;
         found_ff     <= 1'b0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         i_ff         <= i_in;
         e_ff         <= e_in;
         ecnt_ff      <= ecnt_in;
         live_ff      <= live_in;
         layer_ff     <= layer_in;
         cnt_ff       <= cnt_in;
         lcnt_ff      <= lcnt_in;
         entry_ff     <= entry_in;
         err_ff       <= err_in;
         cyc_ff       <= cyc_in;
         removed_ff   <= removed_in;
         lim_all_ff   <= lim_all_in;
         found_ff     <= found_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      dp_ff   <= dp_in;
      la_ff   <= la_in;
      lb_ff   <= lb_in;
      p_ff    <= p_in;
      eidx_ff <= eidx_in;
      pw_ff   <= pw_in;
   end

endmodule

// ===== design/forest_leaf_peel_layering.sv =====
// Top level of the forest leaf peeling block: register port and sequencer.
//
//   channel   dir   handshake                    payload
//   req       in    req_valid / req_ready        flp_pkg::req_type
//   rsp       out   rsp_valid / rsp_ready        flp_pkg::rsp_type
//   csr       in    csr_psel/penable/pwrite      node_count at byte address 0
//
// Clear: a sweep of the degree, touch and info memories, no item produced.
// Add edge: two degree read-modify-writes on one port (one for a self-loop).
// Read: an order lookup, then an info lookup. Run: a sweep and an edge link, then
// peeling of leaves layer by layer, a pass for roots, a last sweep and relink.
// Reset starts the same sweep as a clear; req_ready stays low until it ends.
// A waiting result is held in the output register while the next item is taken.
module forest_leaf_peel_layering #(
   parameter int MAX_NODE   = flp_pkg::MAX_NODE_DEF,
   parameter int MAX_DEGREE = flp_pkg::MAX_DEGREE_DEF,
   parameter int MAX_EDGE   = flp_pkg::MAX_EDGE_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  flp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output flp_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int NCW = $clog2(MAX_NODE + 1);
   localparam int CW  = (NCW > 11) ? NCW : 11;
   localparam logic [10:0] NODE_COUNT_RESET = (MAX_NODE > 2047) ? 11'd2047 : 11'(MAX_NODE);

   logic [10:0]    node_count_ff;
   logic [10:0]    node_count_in;
   logic [NCW-1:0] node_limit;
   logic           wr_hit;

   assign csr_pready = 1'b1;
   assign wr_hit = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == flp_pkg::REG_NODE_COUNT);
   assign node_count_in = wr_hit ? csr_pwdata[10:0] : node_count_ff;
   assign csr_prdata = (csr_paddr[2] == flp_pkg::REG_NODE_COUNT) ?
                       {21'd0, node_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // counts above the node store act as the full store
   assign node_limit = (CW'(node_count_ff) > CW'(MAX_NODE)) ? NCW'(MAX_NODE)
                                                             : NCW'(node_count_ff);

   flp_seq #(
      .MAX_NODE(MAX_NODE),
      .MAX_DEGREE(MAX_DEGREE),
      .MAX_EDGE(MAX_EDGE)
   ) u_seq (
      .clock(clock),
      .reset(reset),
      .node_limit(node_limit),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== design/flp_checker.sv =====
// Port-level checker of the leaf peeling block and its bind.
`include "forest_leaf_peel_layering_macros.svh"

module flp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input flp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input flp_pkg::rsp_type rsp_data
);

   `FLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `FLP_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

   `FLP_ASSERT_NEXT(a_clear_silent,
      req_valid && req_ready && (req_data.mode == flp_pkg::MODE_CLEAR) && !rsp_valid,
      !rsp_valid)

   `FLP_ASSERT_NOW(a_root_zero, rsp_valid && !rsp_data.has_parent,
      (rsp_data.entry_parent == 10'd0) && (rsp_data.parent_weight == 64'd0))

endmodule

bind forest_leaf_peel_layering flp_checker u_flp_checker (.*);
